>>> hw/rtl/perspective_point_map_macros.svh
// ----------------------------------------------------------------------------
// perspective point map assertion macros
// shared concurrent assertion forms, clocked on clk, off during rst
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_POINT_MAP_MACROS_SVH
`define PERSPECTIVE_POINT_MAP_MACROS_SVH

// same-cycle implication
`define PPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppm check failed");

// next-cycle implication
`define PPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppm check failed");

`endif

>>> hw/rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// types, widths and helpers shared by the perspective point map
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int COEF_W   = 48;
  localparam int COEF_N   = 8;
  localparam int IDX_W    = 4;
  localparam int PIX_W    = 12;
  localparam int PROD_W   = 61;
  localparam int SUM_W    = 63;
  localparam int MAG_W    = 62;
  localparam int REM_W    = 63;
  localparam int QB       = 33;
  localparam int FRAC     = 16;
  localparam int PRE      = QB - FRAC;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;
  localparam int Q_CW     = 3;

  localparam logic [COEF_W-1:0] COEF_ONE = 48'h0001_0000_0000;
  localparam logic [2:0] IDX_M11 = 3'd0;
  localparam logic [2:0] IDX_M22 = 3'd4;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic z_neg;
    logic z_zero;
    logic big_x;
    logic big_y;
  } ppm_side_t;

  typedef struct packed {
    logic [MAG_W-1:0] nx;
    logic [MAG_W-1:0] ny;
    logic [MAG_W-1:0] dz;
    ppm_side_t        side;
  } ppm_item_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [Q_CW-1:0] count;
  } ppm_qstat_t;

  typedef struct packed {
    logic [REM_W-1:0] rx;
    logic [REM_W-1:0] ry;
    logic [QB-1:0]    lqx;
    logic [QB-1:0]    lqy;
    logic [MAG_W-1:0] d;
    ppm_side_t        side;
  } ppm_stage_t;

  typedef struct packed {
    logic [REM_W-1:0] r;
    logic [QB-1:0]    lq;
  } ppm_div_t;

  typedef struct packed {
    logic        flag;
    logic [15:0] val;
  } ppm_sat_t;

  // one restoring division step: next dividend bit in, one quotient bit out
  function automatic ppm_div_t div_step(logic [REM_W-1:0] r, logic [QB-1:0] lq,
                                        logic [MAG_W-1:0] d);
    logic [REM_W-1:0] t;
    ppm_div_t         o;
    t = {r[REM_W-2:0], lq[QB-1]};
    if (t >= REM_W'(d)) begin
      o.r  = t - REM_W'(d);
      o.lq = {lq[QB-2:0], 1'b1};
    end else begin
      o.r  = t;
      o.lq = {lq[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  // signed result from magnitude and sign, clamped to 16 bits
  function automatic ppm_sat_t sat16(logic [18:0] mag, logic neg);
    ppm_sat_t o;
    if (!neg) begin
      o.flag = (mag > 19'd32767);
      o.val  = o.flag ? 16'h7FFF : mag[15:0];
    end else begin
      o.flag = (mag > 19'd32768);
      o.val  = o.flag ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/ppm_ifs.sv
// ----------------------------------------------------------------------------
// ppm channel interfaces
// point input, mapped result output and coefficient write channels
// ----------------------------------------------------------------------------
interface ppm_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface ppm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] map_col;
  logic signed [15:0] map_row;
  logic               invalid;
  modport source (output valid, map_col, map_row, invalid, input ready);
  modport sink (input valid, map_col, map_row, invalid, output ready);
endinterface

interface ppm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ppm_front.sv
// ----------------------------------------------------------------------------
// ppm_front
// coefficient registers, x/y/z products and sums, sign and magnitude split
// ----------------------------------------------------------------------------
module ppm_front (
  input  logic              clk,
  input  logic              rst,
  ppm_in_if.sink            pt_in,
  ppm_cfg_if.sink           cfg,
  input  logic              q_full,
  output logic              item_valid,
  output ppm_pkg::ppm_item_t item
);
  import ppm_pkg::*;

  logic [COEF_W-1:0] coef [COEF_N];
  logic              en;
  logic              v1, v2, v3;
  logic signed [PROD_W-1:0] p11, p12, p21, p22, p31, p32;
  logic signed [SUM_W-1:0]  x, y, z;
  logic [MAG_W-1:0]  nx, ny, dz;
  logic              xn, yn, zn, zz;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_N; i++) begin
        coef[i] <= '0;
      end
      coef[IDX_M11] <= COEF_ONE;
      coef[IDX_M22] <= COEF_ONE;
    end else if (cfg.valid && !cfg.index[IDX_W-1]) begin
      coef[cfg.index[2:0]] <= cfg.data;
    end
  end

  assign en          = !v3 || !q_full;
  assign pt_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= pt_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p11 <= $signed(coef[0]) * $signed({1'b0, pt_in.pixel_x});
      p12 <= $signed(coef[1]) * $signed({1'b0, pt_in.pixel_y});
      p21 <= $signed(coef[3]) * $signed({1'b0, pt_in.pixel_x});
      p22 <= $signed(coef[4]) * $signed({1'b0, pt_in.pixel_y});
      p31 <= $signed(coef[6]) * $signed({1'b0, pt_in.pixel_x});
      p32 <= $signed(coef[7]) * $signed({1'b0, pt_in.pixel_y});
      x   <= SUM_W'(p11) + SUM_W'(p12) + SUM_W'($signed(coef[2]));
      y   <= SUM_W'(p21) + SUM_W'(p22) + SUM_W'($signed(coef[5]));
      z   <= SUM_W'(p31) + SUM_W'(p32) + SUM_W'($signed(COEF_ONE));
      xn  <= x[SUM_W-1];
      yn  <= y[SUM_W-1];
      zn  <= z[SUM_W-1];
      zz  <= (z == '0);
      nx  <= x[SUM_W-1] ? MAG_W'(-x) : MAG_W'(x);
      ny  <= y[SUM_W-1] ? MAG_W'(-y) : MAG_W'(y);
      dz  <= z[SUM_W-1] ? MAG_W'(-z) : MAG_W'(z);
    end
  end

  // quotient at or above 2^33 saturates every output that uses it
  assign item_valid       = v3;
  assign item.nx          = nx;
  assign item.ny          = ny;
  assign item.dz          = dz;
  assign item.side.x_neg  = xn;
  assign item.side.y_neg  = yn;
  assign item.side.z_neg  = zn;
  assign item.side.z_zero = zz;
  assign item.side.big_x  = {{PRE{1'b0}}, nx} >= {dz, {PRE{1'b0}}};
  assign item.side.big_y  = {{PRE{1'b0}}, ny} >= {dz, {PRE{1'b0}}};

endmodule

>>> hw/rtl/ppm_queue.sv
// ----------------------------------------------------------------------------
// ppm_queue
// short register queue between the front and the divider pipeline
// ----------------------------------------------------------------------------
module ppm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ppm_pkg::ppm_item_t  din,
  input  logic                pop,
  output ppm_pkg::ppm_item_t  dout,
  output ppm_pkg::ppm_qstat_t stat
);
  import ppm_pkg::*;

  ppm_item_t       mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr, rptr;
  logic [Q_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  assign dout       = mem[rptr];
  assign stat.count = count;
  assign stat.full  = (count == Q_CW'(Q_DEPTH));
  assign stat.empty = (count == '0);

endmodule

>>> hw/rtl/ppm_back.sv
// ----------------------------------------------------------------------------
// ppm_back
// pipelined x/z and y/z division, map offset, saturation and output register
// ----------------------------------------------------------------------------
module ppm_back #(
  parameter int MAP_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  ppm_pkg::ppm_item_t head,
  input  logic               q_empty,
  output logic               pop,
  ppm_out_if.source          pt_out
);
  import ppm_pkg::*;

  localparam logic signed [35:0] ROW_BASE = 36'(MAP_WIDTH * 65536);

  logic       be;
  logic       vld    [QB];
  ppm_stage_t stg    [QB];
  ppm_stage_t stg_in [QB];
  ppm_stage_t init;
  ppm_stage_t last;

  logic [QB:0]        qmx, qmy;
  logic signed [35:0] qx, rowq;
  logic [35:0]        rabs;
  ppm_sat_t           col_s, row_s;

  assign be  = !pt_out.valid || pt_out.ready;
  assign pop = be && !q_empty;

  always_comb begin
    init.rx   = REM_W'(head.nx[MAG_W-1:PRE]);
    init.ry   = REM_W'(head.ny[MAG_W-1:PRE]);
    init.lqx  = {head.nx[PRE-1:0], {FRAC{1'b0}}};
    init.lqy  = {head.ny[PRE-1:0], {FRAC{1'b0}}};
    init.d    = head.dz;
    init.side = head.side;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    ppm_stage_t src;
    ppm_div_t   sx, sy;
    logic       vin;
    if (k == 0) begin : g_first
      assign src = init;
      assign vin = !q_empty;
    end else begin : g_rest
      assign src = stg[k-1];
      assign vin = vld[k-1];
    end
    assign sx = div_step(src.rx, src.lqx, src.d);
    assign sy = div_step(src.ry, src.lqy, src.d);
    always_comb begin
      stg_in[k]      = src;
      stg_in[k].rx   = sx.r;
      stg_in[k].lqx  = sx.lq;
      stg_in[k].ry   = sy.r;
      stg_in[k].lqy  = sy.lq;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (be) begin
        vld[k] <= vin;
      end
    end
    always_ff @(posedge clk) begin
      if (be) begin
        stg[k] <= stg_in[k];
      end
    end
  end

  assign last = stg[QB-1];

  always_comb begin
    qmx   = last.side.big_x ? {1'b1, {QB{1'b0}}} : {1'b0, last.lqx};
    qmy   = last.side.big_y ? {1'b1, {QB{1'b0}}} : {1'b0, last.lqy};
    col_s = sat16(19'(qmy[QB:FRAC]), last.side.y_neg ^ last.side.z_neg);
    qx    = (last.side.x_neg ^ last.side.z_neg) ? -$signed(36'(qmx)) : $signed(36'(qmx));
    rowq  = ROW_BASE - qx;
    rabs  = rowq[35] ? 36'(-rowq) : 36'(rowq);
    row_s = sat16(rabs[34:FRAC], rowq[35]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_out.valid <= 1'b0;
    end else if (be) begin
      pt_out.valid <= vld[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      if (last.side.z_zero) begin
        pt_out.map_col <= last.side.y_neg ? 16'sh8000 : 16'sh7FFF;
        pt_out.map_row <= last.side.x_neg ? 16'sh7FFF : 16'sh8000;
        pt_out.invalid <= 1'b1;
      end else begin
        pt_out.map_col <= col_s.val;
        pt_out.map_row <= row_s.val;
        pt_out.invalid <= col_s.flag || row_s.flag;
      end
    end
  end

endmodule

>>> hw/rtl/perspective_point_map.sv
// ----------------------------------------------------------------------------
// perspective_point_map
// maps a camera pixel point through an eight-coefficient plane homography
// ----------------------------------------------------------------------------
// Takes one point per clock while not stalled by a full queue and returns
// map_col = trunc(y/z) and map_row = trunc(MAP_WIDTH - x/z), saturated to 16
// bits with invalid set on saturation or a zero z. A point passes three front
// stages (products, sums, magnitudes), the four-entry queue, 33 one-bit stages
// of the two parallel restoring dividers, and the output register.
// Coefficients are written through cfg, one 48-bit Q16.32 value per transfer,
// by the user only while no point is in flight; the block does not enforce this.
`include "perspective_point_map_macros.svh"

module perspective_point_map #(
  parameter int MAP_WIDTH = 1024
) (
  input  logic       clk,
  input  logic       rst,
  ppm_in_if.sink     pt_in,
  ppm_out_if.source  pt_out,
  ppm_cfg_if.sink    cfg
);
  import ppm_pkg::*;

  logic       front_valid;
  ppm_item_t  front_item;
  ppm_item_t  q_head;
  ppm_qstat_t qstat;
  logic       q_push, q_pop;

  ppm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pt_in      (pt_in),
    .cfg        (cfg),
    .q_full     (qstat.full),
    .item_valid (front_valid),
    .item       (front_item)
  );

  assign q_push = front_valid && !qstat.full;

  ppm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (front_item),
    .pop  (q_pop),
    .dout (q_head),
    .stat (qstat)
  );

  ppm_back #(
    .MAP_WIDTH (MAP_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (qstat.empty),
    .pop     (q_pop),
    .pt_out  (pt_out)
  );

  `PPM_ASSERT_NEXT(a_front_hold, front_valid && qstat.full, front_valid)
  `PPM_ASSERT_NOW(a_q_bound, 1'b1, qstat.count <= Q_CW'(Q_DEPTH))
  `PPM_ASSERT_NOW(a_q_flags, 1'b1, qstat.empty == (qstat.count == '0))

endmodule

>>> test/ppm_test_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm test interface note
// the channel interfaces come from the design sources; this file only holds
// a small record type used by the testbench
// ----------------------------------------------------------------------------
package ppm_test_pkg;

  typedef struct {
    logic signed [15:0] map_col;
    logic signed [15:0] map_row;
    logic               invalid;
  } mapped_point_t;

endpackage

>>> test/perspective_point_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_map_test
// checks the homography point mapper against a built-in fixed point predictor
// ----------------------------------------------------------------------------
// Drives points with random gaps and output stalls; after the reset identity
// phase writes the eight coefficients (extremes, zero divisor, random sets),
// and compares every mapped result field by field in transfer order.
// ----------------------------------------------------------------------------
import ppm_pkg::*;
import ppm_test_pkg::*;

class map_scoreboard;
  logic [47:0]   coefs [8];
  mapped_point_t pending [$];
  int            errors;
  int            checked;

  function new();
    errors  = 0;
    checked = 0;
    reset_coefs();
  endfunction

  function void reset_coefs();
    foreach (coefs[i]) coefs[i] = '0;
    coefs[0] = 48'h0001_0000_0000;
    coefs[4] = 48'h0001_0000_0000;
  endfunction

  function void write_coef(logic [3:0] idx, logic [47:0] val);
    if (idx < 8) coefs[idx] = val;
  endfunction

  function logic signed [63:0] quot(logic signed [63:0] num, logic signed [63:0] den);
    logic [127:0] n;
    logic [63:0]  d;
    logic [64:0]  r;
    logic [63:0]  q;
    logic         sat;
    n   = '0;
    d   = den < 0 ? -den : den;
    n   = {64'd0, (num < 0 ? -num : num)} << 16;
    r   = '0;
    q   = '0;
    sat = 0;
    for (int i = 127; i >= 0; i--) begin
      logic b;
      b = 0;
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        b = 1;
      end
      if (!sat) begin
        q = {q[62:0], b};
        if (q > 64'd1099511627776) sat = 1;
      end
    end
    if (sat) q = 64'd1099511627776;
    return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function logic signed [63:0] trunc16(logic signed [63:0] v);
    logic signed [63:0] m;
    m = (v < 0 ? -v : v) >>> 16;
    return v < 0 ? -m : m;
  endfunction

  function logic [15:0] clamp(logic signed [63:0] v, inout logic flag);
    if (v > 32767) begin
      flag = 1;
      return 16'h7FFF;
    end
    if (v < -32768) begin
      flag = 1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function void note_point(logic [11:0] px, logic [11:0] py);
    logic signed [63:0] c [8];
    logic signed [63:0] x, y, z, sx, sy, xi, yi;
    mapped_point_t      e;
    logic               flag;
    foreach (c[i]) c[i] = {{16{coefs[i][47]}}, coefs[i]};
    xi = {52'd0, px};
    yi = {52'd0, py};
    x = c[0] * xi + c[1] * yi + c[2];
    y = c[3] * xi + c[4] * yi + c[5];
    z = c[6] * xi + c[7] * yi + 64'sh1_0000_0000;
    flag = 0;
    if (z == 0) begin
      e.map_col = (y >= 0) ? 16'h7FFF : 16'h8000;
      e.map_row = (x >= 0) ? 16'h8000 : 16'h7FFF;
      e.invalid = 1;
    end else begin
      sx = quot(x, z);
      sy = quot(y, z);
      e.map_col = clamp(trunc16(sy), flag);
      e.map_row = clamp(trunc16(64'sd1024 * 65536 - sx), flag);
      e.invalid = flag;
    end
    pending.push_back(e);
  endfunction

  function void check_result(mapped_point_t got);
    mapped_point_t e;
    if (pending.size() == 0) begin
      $error("unexpected result col %0d row %0d", got.map_col, got.map_row);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (got.map_col !== e.map_col) begin
      $error("map_col expected %0d actual %0d", e.map_col, got.map_col);
      errors++;
    end
    if (got.map_row !== e.map_row) begin
      $error("map_row expected %0d actual %0d", e.map_row, got.map_row);
      errors++;
    end
    if (got.invalid !== e.invalid) begin
      $error("invalid expected %0b actual %0b", e.invalid, got.invalid);
      errors++;
    end
  endfunction
endclass

module perspective_point_map_test;
  logic clk = 0;
  logic rst = 1;

  ppm_in_if  pt_in ();
  ppm_out_if pt_out ();
  ppm_cfg_if cfg ();

  perspective_point_map u_top (
    .clk   (clk),
    .rst   (rst),
    .pt_in (pt_in.sink),
    .pt_out(pt_out.source),
    .cfg   (cfg.sink)
  );

  always #1 clk = ~clk;

  map_scoreboard board = new();
  bit   no_idle      = 0;
  bit   hold_off_req = 0;
  int   idle_cycles  = 0;
  int   points_sent  = 0;
  int   cfg_writes   = 0;
  localparam int WATCHDOG = 20000;

  initial begin
    pt_in.valid   = 0;
    pt_in.pixel_x = '0;
    pt_in.pixel_y = '0;
    pt_out.ready  = 0;
    cfg.valid     = 0;
    cfg.index     = '0;
    cfg.data      = '0;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(negedge clk);
    while (1) begin
      if (hold_off_req) begin
        pt_out.ready <= 0;
        repeat (300) @(negedge clk);
        hold_off_req = 0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        pt_out.ready <= 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        pt_out.ready <= 1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    mapped_point_t got;
    if (!rst && pt_out.valid && pt_out.ready) begin
      got.map_col = pt_out.map_col;
      got.map_row = pt_out.map_row;
      got.invalid = pt_out.invalid;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready)
        || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_point(logic [11:0] px, logic [11:0] py);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      pt_in.valid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    pt_in.valid   <= 1;
    pt_in.pixel_x <= px;
    pt_in.pixel_y <= py;
    @(posedge clk);
    while (!pt_in.ready) @(posedge clk);
    board.note_point(px, py);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    pt_in.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_coef(logic [3:0] idx, logic [47:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    board.write_coef(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
  endtask

  task automatic load_set(logic [47:0] v [8]);
    for (int i = 0; i < 8; i++) write_coef(i[3:0], v[i]);
  endtask

  function automatic logic [47:0] rnd_q32(int ip);
    logic signed [47:0] v;
    v = 48'($signed({$urandom, $urandom}) >>> (48 - 32 - ip));
    return v;
  endfunction

  task automatic random_points(int count, bit corners);
    for (int i = 0; i < count; i++) begin
      if (corners && $urandom_range(0, 7) == 0)
        send_point($urandom_range(0, 1) ? 12'hFFF : 12'h000,
                   $urandom_range(0, 1) ? 12'hFFF : 12'h000);
      else
        send_point(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    logic [47:0] s [8];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // identity after reset
    send_point(0, 0);
    send_point(4095, 4095);
    send_point(4095, 0);
    send_point(0, 4095);
    send_point(1024, 100);
    drain();

    // extreme coefficients, out of range index ignored
    s = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
          48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
          48'h0000_0000_0000, 48'h0000_0000_0000};
    load_set(s);
    write_coef(4'd9, 48'h1234_5678_9ABC);
    send_point(0, 0);
    send_point(4095, 4095);
    send_point(1, 4095);
    drain();

    // zero divisor: z = 1 - px, so px = 1 gives z = 0 with m31 = -1
    s = '{48'h0000_0001_0000, 48'hFFFF_FFFF_0000, 48'h0, 48'hFFFF_FFFF_0000,
          48'h0000_0002_0000, 48'h0, 48'hFFFF_0000_0000, 48'h0};
    load_set(s);
    send_point(1, 0);
    send_point(1, 5);
    send_point(1, 4095);
    send_point(2, 3);
    send_point(0, 7);
    drain();
    s = '{48'hFFFF_FFFF_0000, 48'h0, 48'h0, 48'h0, 48'h0, 48'hFFFF_0000_0000,
          48'h0, 48'hFFFF_0000_0000};
    load_set(s);
    send_point(5, 1);
    send_point(0, 2);
    send_point(9, 9);
    drain();
    // tiny divisor, huge quotient
    s[7] = 48'hFFFF_0000_0001;
    write_coef(4'd7, s[7]);
    send_point(4095, 1);
    drain();

    // random phases with varying coefficient scales
    for (int ph = 0; ph < 14; ph++) begin
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 4))
          0: s[i] = rnd_q32(15);
          1: s[i] = rnd_q32(0);
          2: s[i] = (i == 6 || i == 7) ? rnd_q32(-12) : rnd_q32(4);
          3: s[i] = 48'({$urandom, $urandom});
          default: s[i] = (i == 0 || i == 4) ? 48'h0001_0000_0000 : rnd_q32(-2);
        endcase
      end
      load_set(s);
      if (ph == 5) begin
        hold_off_req = 1;
        random_points(40, 1);
      end
      if (ph >= 12) no_idle = 1;
      random_points(110, 1);
      drain();
    end

    $display("sent %0d points over %0d coefficient writes, %0d results checked",
             points_sent, cfg_writes, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
